// ===== design/itfe_pkg.sv =====
`default_nettype none

package itfe_pkg;

	// Input item as it arrives on the item channel
	typedef struct packed {
		logic               action;
		logic [15:0]        sequence_req;
		logic [31:0]        sample_time;
		logic [15:0]        status_word;
		logic signed [31:0] measured_value;
	} itfe_item_t;

	// One frame byte as it leaves on the result channel
	typedef struct packed {
		logic [7:0] out_byte;
		logic [5:0] byte_index;
		logic       frame_end;
	} itfe_result_t;

	localparam int STATUS_W = 9;

	// Classified work handed from the front to the back through the queue
	typedef struct packed {
		logic                is_hdr;
		logic [3:0]          slot;
		logic [15:0]         seq_num;
		logic [31:0]         timestamp;
		logic [STATUS_W-1:0] status;
		logic [7:0]          version;
		logic [15:0]         code;
	} itfe_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} itfe_qstat_t;

	localparam logic ACT_HEADER = 1'b0;

	localparam logic [7:0] SYNC_0        = 8'hA5;
	localparam logic [7:0] SYNC_1        = 8'h5A;
	localparam logic [7:0] FRAME_LEN     = 8'd34;
	localparam logic [7:0] VERSION_RESET = 8'd1;

	localparam logic [3:0] LAST_SLOT      = 4'd12;
	localparam logic [3:0] HDR_LAST_CNT   = 4'd11;
	localparam logic [3:0] ANGLE_SLOT_END = 4'd3;
	localparam logic [3:0] GYRO_SLOT_END  = 4'd6;
	localparam logic [3:0] ACCEL_SLOT_END = 4'd9;

	localparam logic [5:0] HDR_FIRST_IDX  = 6'd0;
	localparam logic [5:0] VALUE_BASE_IDX = 6'd12;
	localparam logic [5:0] CRC_FIRST_IDX  = 6'd2;
	localparam logic [5:0] CRC_LAST_IDX   = 6'd37;
	localparam logic [5:0] CRC_LO_IDX     = 6'd38;
	localparam logic [5:0] CRC_HI_IDX     = 6'd39;

	localparam logic [15:0] SCALE_ANGLE = 16'd100;
	localparam logic [15:0] SCALE_GYRO  = 16'd10;
	localparam logic [15:0] SCALE_ACCEL = 16'd1000;
	localparam logic [15:0] SCALE_QUAT  = 16'd32767;

	localparam logic [15:0] INT16_MAX_CODE = 16'h7FFF;
	localparam logic [15:0] INT16_MIN_CODE = 16'h8000;

	// 360 degrees expressed in units of eight degrees
	localparam int TURN_UNITS    = 45;
	localparam int HALF_TURN_DEG = 180;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int QPTR_W      = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_W;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/imu_telemetry_frame_encoder_unit.sv =====
// IMU telemetry frame encoder.
// Item channel (item_valid / item_stall / item): a header item (action 0) opens
// a 40-byte frame; thirteen value items (action 1, signed fixed point) follow.
// A value with no frame open is dropped; a header restarts the frame.
// Result channel (result_valid / result_stall / result): one frame byte per
// transfer with its offset and an end flag on byte 39.
// Config channel (cfg_valid / cfg_ready / cfg_data): protocol version byte,
// always ready, sampled by each header; write it only while the block is idle.
// The first byte of an item passes the six front stages, the queue, the byte
// sequencer and the output register on its way out.
// The byte sequencer sends one byte per cycle unless the receiver stalls, so a
// value item yields two bytes, a header twelve, the last value four with the CRC.
// The front accepts one item per cycle until its four-entry queue fills.
// Reset clears the frame state, the queue and the output valid, and loads the
// version with 1 and the CRC with FFFF.
// A stalled receiver holds the output byte; the sequencer, then the queue,
// then the front pipe hold in turn and item_stall rises.
`default_nettype none

module imu_telemetry_frame_encoder_unit
	import itfe_pkg::*;
#(
	parameter int VALUE_FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire itfe_item_t   item,
	output logic              result_valid,
	input  wire logic         result_stall,
	output itfe_result_t      result,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_data
);

	itfe_qstat_t qstat;
	itfe_cmd_t   push_cmd, head_cmd;
	logic        push, pop;

	// Register writes are always accepted
	assign cfg_ready = 1'b1;

	// Front: accept, track the frame slot, wrap and quantize values
	itfe_front #(
		.VALUE_FRAC_BITS(VALUE_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.push       (push),
		.cmd        (push_cmd)
	);

	// Short queue decouples the front pipe from the byte sequencer
	itfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.head   (head_cmd),
		.qstat  (qstat)
	);

	// Back: serialize bytes, run the CRC, drive the output register
	itfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_cmd),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.frame_end == (result.byte_index == CRC_HI_IDX)))
		else $error("frame_end disagrees with byte offset");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.full |-> !item_stall)
		else $error("item channel stalled with queue room");

endmodule

`default_nettype wire

// ===== design/itfe_front.sv =====
`default_nettype none

module itfe_front
	import itfe_pkg::*;
#(
	parameter int VALUE_FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire itfe_item_t   item,
	input  wire logic         cfg_valid,
	input  wire logic [7:0]   cfg_data,
	input  wire itfe_qstat_t  qstat,
	output logic              push,
	output itfe_cmd_t         cmd
);

	// Angle wrap: y = v + 180<<F + 45<<31 is always positive and keeps the same
	// residue modulo 360<<F. Its bits from F+3 up are taken modulo 45 through a
	// reciprocal multiply, the bits below pass unchanged.
	localparam int SH = VALUE_FRAC_BITS + 3;
	localparam int NW = 34 - VALUE_FRAC_BITS;
	localparam int PW = 2 * NW - 5;
	localparam int YW = 37;
	localparam logic [YW-1:0] HALF_Y = YW'(HALF_TURN_DEG) << VALUE_FRAC_BITS;
	localparam logic [YW-1:0] BIAS = HALF_Y + (YW'(TURN_UNITS) << 31);
	localparam logic [NW-6:0] RECIP = (NW-5)'((64'd1 << NW) / TURN_UNITS);
	localparam logic [SH+5:0] HALF_W = (SH+6)'(HALF_TURN_DEG) << VALUE_FRAC_BITS;
	localparam logic [48:0] RND_HALF = 49'd1 << (VALUE_FRAC_BITS - 1);

	logic       adv, accept, keep;
	logic       frame_open_q;
	logic [3:0] slot_q;
	logic [7:0] version_q;

	logic [YW-1:0] y_in;
	itfe_cmd_t     cmd_in;
	itfe_cmd_t     cmd_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	itfe_cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic signed [31:0] val_s1, val_s2, val_s3;
	logic [NW-1:0] hi_s1, hi_s2;
	logic [SH-1:0] lo_s1, lo_s2, lo_s3;
	logic [NW-6:0] q_s2;
	logic [5:0]    r_s3;
	logic signed [31:0] w_s4;
	logic [15:0]   scale_s4;
	logic signed [48:0] prod_s5;

	logic [PW-1:0] qprod;
	logic [NW-1:0] rem_raw;
	logic [5:0]    rem_fix;
	logic signed [SH+6:0] wdiff;
	logic          is_angle;
	logic [15:0]   scale_c;
	logic          neg;
	logic [48:0]   rnd, qv;
	logic [15:0]   code_c;

	// The whole pipe moves together; hold it only when the queue cannot take
	// the last stage.
	assign adv        = !v_s6 || !qstat.full;
	assign item_stall = !adv;
	assign accept     = item_valid && adv;
	assign keep       = accept && (item.action == ACT_HEADER || frame_open_q);

	assign y_in = {{5{item.measured_value[31]}}, item.measured_value} + BIAS;

	always_comb begin
		cmd_in           = '0;
		cmd_in.is_hdr    = (item.action == ACT_HEADER);
		cmd_in.slot      = slot_q;
		cmd_in.seq_num   = item.sequence_req;
		cmd_in.timestamp = item.sample_time;
		cmd_in.status    = item.status_word[STATUS_W-1:0];
		cmd_in.version   = version_q;
	end

	assign qprod   = PW'(hi_s1) * PW'(RECIP);
	assign rem_raw = hi_s2 - NW'(q_s2) * NW'(TURN_UNITS);
	assign rem_fix = (rem_raw >= NW'(TURN_UNITS)) ? 6'(rem_raw - NW'(TURN_UNITS))
	                                              : 6'(rem_raw);
	assign wdiff   = $signed({1'b0, r_s3, lo_s3}) - $signed({1'b0, HALF_W});

	assign is_angle = !cmd_s3.is_hdr && (cmd_s3.slot < ANGLE_SLOT_END);

	always_comb begin
		priority if (cmd_s3.slot < ANGLE_SLOT_END) begin
			scale_c = SCALE_ANGLE;
		end else if (cmd_s3.slot < GYRO_SLOT_END) begin
			scale_c = SCALE_GYRO;
		end else if (cmd_s3.slot < ACCEL_SLOT_END) begin
			scale_c = SCALE_ACCEL;
		end else begin
			scale_c = SCALE_QUAT;
		end
	end

	// Round half away from zero: for a negative product, -p + h = ~p + h + 1.
	assign neg = prod_s5[48];
	assign rnd = (neg ? ~prod_s5 : prod_s5) + (neg ? RND_HALF + 49'd1 : RND_HALF);
	assign qv  = rnd >> VALUE_FRAC_BITS;

	always_comb begin
		if (neg) begin
			code_c = (qv > {33'd0, INT16_MIN_CODE}) ? INT16_MIN_CODE : 16'd0 - qv[15:0];
		end else begin
			code_c = (qv > {33'd0, INT16_MAX_CODE}) ? INT16_MAX_CODE : qv[15:0];
		end
	end

	// Merge the quantized code into the command for the last stage
	always_comb begin
		cmd_c      = cmd_s5;
		cmd_c.code = code_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			slot_q       <= '0;
			version_q    <= VERSION_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				version_q <= cfg_data;
			end
			if (accept) begin
				if (item.action == ACT_HEADER) begin
					frame_open_q <= 1'b1;
					slot_q       <= '0;
				end else if (frame_open_q) begin
					if (slot_q == LAST_SLOT) begin
						frame_open_q <= 1'b0;
						slot_q       <= '0;
					end else begin
						slot_q <= slot_q + 4'd1;
					end
				end
			end
			if (adv) begin
				v_s1 <= keep;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_in;
			val_s1 <= item.measured_value;
			hi_s1  <= y_in[SH+NW-1:SH];
			lo_s1  <= y_in[SH-1:0];

			cmd_s2 <= cmd_s1;
			val_s2 <= val_s1;
			hi_s2  <= hi_s1;
			lo_s2  <= lo_s1;
			q_s2   <= qprod[PW-1:NW];

			cmd_s3 <= cmd_s2;
			val_s3 <= val_s2;
			lo_s3  <= lo_s2;
			r_s3   <= rem_fix;

			cmd_s4   <= cmd_s3;
			w_s4     <= is_angle ? 32'(wdiff) : val_s3;
			scale_s4 <= scale_c;

			cmd_s5  <= cmd_s4;
			prod_s5 <= 49'(w_s4) * 49'($signed({1'b0, scale_s4}));

			cmd_s6 <= cmd_c;
		end
	end

	assign push = v_s6 && !qstat.full;
	assign cmd  = cmd_s6;

endmodule

`default_nettype wire

// ===== design/itfe_queue.sv =====
`default_nettype none

module itfe_queue
	import itfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire itfe_cmd_t   wr_cmd,
	input  wire logic        pop,
	output itfe_cmd_t        head,
	output itfe_qstat_t      qstat
);

	itfe_cmd_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign qstat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== design/itfe_back.sv =====
`default_nettype none

module itfe_back
	import itfe_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire itfe_cmd_t    head,
	input  wire itfe_qstat_t  qstat,
	output logic              pop,
	output logic              result_valid,
	input  wire logic         result_stall,
	output itfe_result_t      result
);

	itfe_cmd_t    cmd_q;
	logic         busy_q;
	logic [3:0]   cnt_q;
	logic [15:0]  crc_q;
	logic         out_valid_q;
	itfe_result_t result_q;

	logic       out_load, gen_en, last_byte, finishing;
	logic [7:0] byte_c;
	logic [5:0] idx_c;
	logic       end_c;

	assign out_load  = !out_valid_q || !result_stall;
	assign gen_en    = busy_q && out_load;
	assign finishing = gen_en && last_byte;
	assign pop       = !qstat.empty && (!busy_q || finishing);

	always_comb begin
		byte_c    = '0;
		idx_c     = '0;
		end_c     = 1'b0;
		last_byte = 1'b0;
		if (cmd_q.is_hdr) begin
			idx_c     = {2'b00, cnt_q};
			last_byte = (cnt_q == HDR_LAST_CNT);
			unique case (cnt_q)
				4'd0:    byte_c = SYNC_0;
				4'd1:    byte_c = SYNC_1;
				4'd2:    byte_c = cmd_q.version;
				4'd3:    byte_c = FRAME_LEN;
				4'd4:    byte_c = cmd_q.seq_num[7:0];
				4'd5:    byte_c = cmd_q.seq_num[15:8];
				4'd6:    byte_c = cmd_q.timestamp[7:0];
				4'd7:    byte_c = cmd_q.timestamp[15:8];
				4'd8:    byte_c = cmd_q.timestamp[23:16];
				4'd9:    byte_c = cmd_q.timestamp[31:24];
				4'd10:   byte_c = cmd_q.status[7:0];
				4'd11:   byte_c = 8'(cmd_q.status >> 8);
				default: byte_c = '0;
			endcase
		end else begin
			// Two code bytes, then the CRC bytes after the last slot
			last_byte = (cnt_q[1:0] == 2'd3) ||
			            (cnt_q[1:0] == 2'd1 && cmd_q.slot != LAST_SLOT);
			unique case (cnt_q[1:0])
				2'd0: begin
					byte_c = cmd_q.code[7:0];
					idx_c  = VALUE_BASE_IDX + {1'b0, cmd_q.slot, 1'b0};
				end
				2'd1: begin
					byte_c = cmd_q.code[15:8];
					idx_c  = VALUE_BASE_IDX + {1'b0, cmd_q.slot, 1'b1};
				end
				2'd2: begin
					byte_c = crc_q[7:0];
					idx_c  = CRC_LO_IDX;
				end
				2'd3: begin
					byte_c = crc_q[15:8];
					idx_c  = CRC_HI_IDX;
					end_c  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end else if (gen_en) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (gen_en) begin
				if (idx_c == HDR_FIRST_IDX) begin
					crc_q <= CRC_INIT;
				end else if (idx_c >= CRC_FIRST_IDX && idx_c <= CRC_LAST_IDX) begin
					crc_q <= crc16_byte(crc_q, byte_c);
				end
			end
			if (out_load) begin
				out_valid_q <= gen_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (gen_en) begin
			result_q.out_byte   <= byte_c;
			result_q.byte_index <= idx_c;
			result_q.frame_end  <= end_c;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
